@@ design/vmx_pkg.sv @@
`default_nettype none

package vmx_pkg;

    // Default sizes of the storage and the special register positions.
    localparam int DEF_NUM_REGS  = 16;
    localparam int DEF_MEM_WORDS = 4096;
    localparam int DEF_FLAG_REG  = 13;
    localparam int DEF_CMP_REG   = 14;
    localparam int DEF_PC_REG    = 15;

    // Width of a register and of a data memory word.
    localparam int DATA_W = 32;

    // Instruction opcodes.
    typedef enum logic [3:0] {
        OP_ADD_RR   = 4'h0,
        OP_ADD_RC   = 4'h1,
        OP_PUSH_POP = 4'h2,
        OP_SUB_RR   = 4'h3,
        OP_LOAD_RR  = 4'h4,
        OP_LOAD_RC  = 4'h5,
        OP_SUB_RC   = 4'h7,
        OP_STORE_RR = 4'h8,
        OP_STORE_RC = 4'h9,
        OP_BRANCH   = 4'hB,
        OP_CMP      = 4'hC,
        OP_IO       = 4'hF
    } opcode_t;

    // Completion status of an instruction.
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_UNSUPPORTED = 2'd1,
        STATUS_UNKNOWN     = 2'd2
    } status_t;

    // Codes held in the compare register.
    localparam logic [DATA_W-1:0] CMP_EQ = 32'd0;
    localparam logic [DATA_W-1:0] CMP_LT = 32'd1;
    localparam logic [DATA_W-1:0] CMP_GT = 32'd2;

    // Write control for the register file.
    typedef struct packed {
        logic en;
        logic flag_set;
    } rf_wctl_t;

    // Signed three-way compare of two register values.
    function automatic logic [DATA_W-1:0] compare(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] res;
        if (a == b)
        begin
            res = CMP_EQ;
        end
        else if ($signed(a) < $signed(b))
        begin
            res = CMP_LT;
        end
        else
        begin
            res = CMP_GT;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/vmx_regfile.sv @@
`default_nettype none

module vmx_regfile #(
    parameter int NUM_REGS = vmx_pkg::DEF_NUM_REGS,
    parameter int FLAG_REG = vmx_pkg::DEF_FLAG_REG,
    parameter int CMP_REG  = vmx_pkg::DEF_CMP_REG,
    parameter int PC_REG   = vmx_pkg::DEF_PC_REG,
    localparam int IDX_W   = $clog2(NUM_REGS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [IDX_W-1:0]            rd_d_idx,
    input  wire logic [IDX_W-1:0]            rd_s_idx,
    input  wire vmx_pkg::rf_wctl_t           wr_ctl,
    input  wire logic [IDX_W-1:0]            wr_idx,
    input  wire logic [vmx_pkg::DATA_W-1:0]  wr_data,
    output logic      [vmx_pkg::DATA_W-1:0]  d_value,
    output logic      [vmx_pkg::DATA_W-1:0]  s_value,
    output logic      [vmx_pkg::DATA_W-1:0]  cmp_value,
    output logic      [vmx_pkg::DATA_W-1:0]  pc_next
);
    import vmx_pkg::*;

    localparam logic [IDX_W-1:0] FLAG_IDX = IDX_W'(FLAG_REG % NUM_REGS);
    localparam logic [IDX_W-1:0] CMP_IDX  = IDX_W'(CMP_REG % NUM_REGS);
    localparam logic [IDX_W-1:0] PC_IDX   = IDX_W'(PC_REG % NUM_REGS);

    logic [DATA_W-1:0] mem [NUM_REGS];
    logic [DATA_W-1:0] rd_d_reg;
    logic [DATA_W-1:0] rd_s_reg;
    logic [IDX_W-1:0]  idx_d_reg;
    logic [IDX_W-1:0]  idx_s_reg;
    logic              fwd_d_reg;
    logic              fwd_s_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic [NUM_REGS-1:0] vld_reg;
    logic [DATA_W-1:0] flag_val_reg;
    logic [DATA_W-1:0] flag_val_next;
    logic [DATA_W-1:0] cmp_val_reg;
    logic [DATA_W-1:0] cmp_val_next;
    logic [DATA_W-1:0] pc_val_reg;
    logic [DATA_W-1:0] pc_val_next;

    // Register array with two synchronous read ports and one write port.
    always_ff @(posedge clk)
    begin
        if (wr_ctl.en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_d_reg     <= mem[rd_d_idx];
            rd_s_reg     <= mem[rd_s_idx];
            idx_d_reg    <= rd_d_idx;
            idx_s_reg    <= rd_s_idx;
            fwd_data_reg <= wr_data;
        end
    end

    // Forwarding marks for a write that lands on the same edge as the read,
    // and written marks so that untouched registers read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_d_reg <= 1'b0;
            fwd_s_reg <= 1'b0;
            vld_reg   <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                fwd_d_reg <= wr_ctl.en && (wr_idx == rd_d_idx);
                fwd_s_reg <= wr_ctl.en && (wr_idx == rd_s_idx);
            end
            if (wr_ctl.en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // Next values of the special registers. The sticky flag is set first, so
    // a plain write to the same position wins.
    always_comb
    begin
        flag_val_next = flag_val_reg;
        cmp_val_next  = cmp_val_reg;
        pc_val_next   = pc_val_reg;
        if (wr_ctl.flag_set)
        begin
            flag_val_next = 32'd1;
            if (CMP_IDX == FLAG_IDX)
            begin
                cmp_val_next = 32'd1;
            end
            if (PC_IDX == FLAG_IDX)
            begin
                pc_val_next = 32'd1;
            end
        end
        if (wr_ctl.en && (wr_idx == FLAG_IDX))
        begin
            flag_val_next = wr_data;
        end
        if (wr_ctl.en && (wr_idx == CMP_IDX))
        begin
            cmp_val_next = wr_data;
        end
        if (wr_ctl.en && (wr_idx == PC_IDX))
        begin
            pc_val_next = wr_data;
        end
    end

    // Special registers are held in flip-flops so they can be read at any time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_val_reg <= '0;
            cmp_val_reg  <= '0;
            pc_val_reg   <= '0;
        end
        else
        begin
            flag_val_reg <= flag_val_next;
            cmp_val_reg  <= cmp_val_next;
            pc_val_reg   <= pc_val_next;
        end
    end

    // Resolve one read port: special register, forwarded write, array or zero.
    function automatic logic [DATA_W-1:0] pick(input logic [IDX_W-1:0]  idx,
                                               input logic              fwd,
                                               input logic              written,
                                               input logic [DATA_W-1:0] q,
                                               input logic [DATA_W-1:0] pc_v,
                                               input logic [DATA_W-1:0] cmp_v,
                                               input logic [DATA_W-1:0] flag_v,
                                               input logic [DATA_W-1:0] fwd_v);
        logic [DATA_W-1:0] res;
        if (idx == PC_IDX)
        begin
            res = pc_v;
        end
        else if (idx == CMP_IDX)
        begin
            res = cmp_v;
        end
        else if (idx == FLAG_IDX)
        begin
            res = flag_v;
        end
        else if (fwd)
        begin
            res = fwd_v;
        end
        else if (written)
        begin
            res = q;
        end
        else
        begin
            res = '0;
        end
        return res;
    endfunction

    assign d_value   = pick(idx_d_reg, fwd_d_reg, vld_reg[idx_d_reg], rd_d_reg,
                            pc_val_reg, cmp_val_reg, flag_val_reg, fwd_data_reg);
    assign s_value   = pick(idx_s_reg, fwd_s_reg, vld_reg[idx_s_reg], rd_s_reg,
                            pc_val_reg, cmp_val_reg, flag_val_reg, fwd_data_reg);
    assign cmp_value = cmp_val_reg;
    assign pc_next   = pc_val_next;

endmodule

`default_nettype wire

@@ design/vmx_addr_mod.sv @@
`default_nettype none

module vmx_addr_mod #(
    parameter int MEM_WORDS = vmx_pkg::DEF_MEM_WORDS,
    localparam int AW       = $clog2(MEM_WORDS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       clear,
    input  wire logic [vmx_pkg::DATA_W-1:0] value,
    output logic                            done,
    output logic      [AW-1:0]              addr
);
    import vmx_pkg::*;

    if ((MEM_WORDS & (MEM_WORDS - 1)) == 0)
    begin : g_pow2
        // A power-of-two depth is a plain mask.
        assign done = 1'b1;
        assign addr = value[AW-1:0];
    end
    else
    begin : g_recip
        // Remainder by multiplication with a truncated reciprocal. The
        // estimated quotient is at most one short, so one subtraction fixes it.
        localparam int SH = 31 + AW;
        localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / 64'(MEM_WORDS);
        localparam logic [DATA_W-1:0] RECIP = RECIP_FULL[DATA_W-1:0];
        localparam logic [AW:0] MOD_C = (AW+1)'(MEM_WORDS);

        logic [DATA_W-1:0] val_reg;
        logic [63:0]       prod_reg;
        logic [DATA_W-1:0] qc_reg;
        logic              v1_reg;
        logic              v2_reg;
        logic [DATA_W-1:0] quot;
        logic [48:0]       qc_full;
        logic [DATA_W-1:0] diff;
        logic [AW:0]       rem;
        logic [AW:0]       rem_fix;

        assign quot    = DATA_W'(prod_reg >> SH);
        assign qc_full = 49'(quot) * 49'(MEM_WORDS);
        assign diff    = val_reg - qc_reg;
        assign rem     = diff[AW:0];
        assign rem_fix = (rem >= MOD_C) ? (rem - MOD_C) : rem;

        // Two multiplier stages, each followed by a register.
        always_ff @(posedge clk)
        begin
            if (start)
            begin
                val_reg  <= value;
                prod_reg <= 64'(value) * 64'(RECIP);
            end
            if (v1_reg)
            begin
                qc_reg <= qc_full[DATA_W-1:0];
            end
        end

        // Stage occupancy; the result stays until the consumer clears it.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v1_reg <= 1'b0;
                v2_reg <= 1'b0;
            end
            else
            begin
                v1_reg <= start;
                v2_reg <= v1_reg || (v2_reg && !clear);
            end
        end

        assign done = v2_reg;
        assign addr = rem_fix[AW-1:0];
    end

endmodule

`default_nettype wire

@@ design/vmx_data_mem.sv @@
`default_nettype none

module vmx_data_mem #(
    parameter int MEM_WORDS = vmx_pkg::DEF_MEM_WORDS,
    localparam int AW       = $clog2(MEM_WORDS)
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [vmx_pkg::DATA_W-1:0] rd_data,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [vmx_pkg::DATA_W-1:0] wr_data
);
    import vmx_pkg::*;

    logic [DATA_W-1:0] mem [MEM_WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    // Word memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/vm_instruction_execute_unit.sv @@
// Pipeline: an accepted instruction passes the execute stage, the write-back stage and the
// output register; when the data memory depth is not a power of two, loads and stores also
// wait in the execute stage for the address reducer. A new instruction is taken only once the
// execute stage is free and the write-back it may depend on is empty or retiring.
// Reset: rst_n empties the pipeline and output register and makes every register read as zero;
// the data memory is not cleared.
`default_nettype none

module vm_instruction_execute_unit #(
    parameter int NUM_REGS  = vmx_pkg::DEF_NUM_REGS,
    parameter int MEM_WORDS = vmx_pkg::DEF_MEM_WORDS,
    parameter int FLAG_REG  = vmx_pkg::DEF_FLAG_REG,
    parameter int CMP_REG   = vmx_pkg::DEF_CMP_REG,
    parameter int PC_REG    = vmx_pkg::DEF_PC_REG
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [3:0]         operation,
    input  wire logic               mode_reset,
    input  wire logic               mode_flag,
    input  wire logic               mode_offset,
    input  wire logic [3:0]         dest_reg,
    input  wire logic [3:0]         source_reg,
    input  wire logic [15:0]        immediate,
    input  wire logic signed [8:0]  char_in,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic                    char_out_valid,
    output logic      [7:0]         char_out,
    output logic signed [31:0]      pc_value,
    output logic      [1:0]         status
);
    import vmx_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int AW    = $clog2(MEM_WORDS);
    localparam logic [IDX_W-1:0] CMP_IDX = IDX_W'(CMP_REG % NUM_REGS);
    localparam logic [IDX_W-1:0] PC_IDX  = IDX_W'(PC_REG % NUM_REGS);

    // Register index taken modulo the register count by repeated subtraction.
    function automatic logic [IDX_W-1:0] reg_mod(input logic [3:0] raw);
        logic [8:0] r;
        r = {5'd0, raw};
        for (int k = 0; k < 3; k++)
        begin
            if (r >= 9'(NUM_REGS))
            begin
                r = r - 9'(NUM_REGS);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // Handshake and stage control.
    logic accept;
    logic out_free;
    logic retire;
    logic s1_adv;
    logic addr_start;
    logic addr_done;

    // Execute stage.
    logic              s1_valid_reg;
    opcode_t           s1_op_reg;
    logic              s1_rst_reg;
    logic              s1_flag_reg;
    logic              s1_offs_reg;
    logic [IDX_W-1:0]  s1_d_reg;
    logic [15:0]       s1_imm_reg;
    logic [8:0]        s1_ch_reg;
    logic              busy_reg;

    // Write-back stage.
    logic              s2_valid_reg;
    logic              s2_wr_en_reg;
    logic              s2_flag_set_reg;
    logic              s2_is_load_reg;
    logic [IDX_W-1:0]  s2_wr_idx_reg;
    logic [DATA_W-1:0] s2_wr_data_reg;
    logic              s2_cv_reg;
    logic [7:0]        s2_cout_reg;
    status_t           s2_status_reg;

    // Output register.
    logic              result_valid_reg;
    logic              cv_out_reg;
    logic [7:0]        cout_out_reg;
    logic [DATA_W-1:0] pc_out_reg;
    status_t           status_out_reg;

    // Execute results.
    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic [DATA_W-1:0] imm32;
    logic [DATA_W-1:0] opnd;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] ovf_vec;
    logic              is_sub;
    logic              take;
    logic              ex_wr_en;
    logic              ex_flag_set;
    logic              ex_is_load;
    logic [IDX_W-1:0]  ex_wr_idx;
    logic [DATA_W-1:0] ex_wr_data;
    logic              ex_cv;
    logic [7:0]        ex_cout;
    status_t           ex_status;
    logic              ex_load;
    logic              ex_store;
    logic [DATA_W-1:0] mem_x;

    // Register file and data memory connections.
    rf_wctl_t          rf_wctl;
    logic [DATA_W-1:0] rf_d_value;
    logic [DATA_W-1:0] rf_s_value;
    logic [DATA_W-1:0] rf_cmp_value;
    logic [DATA_W-1:0] rf_pc_next;
    logic [DATA_W-1:0] rf_wdata;
    logic [AW-1:0]     dm_addr;
    logic [DATA_W-1:0] dm_rdata;
    logic              dm_rd_en;
    logic              dm_wr_en;

    // A new transaction is taken once the execute stage is free and the
    // write-back stage is empty or empties on the same edge, so its register reads can
    // be forwarded from that write.
    assign out_free   = !result_valid_reg || !result_stall;
    assign retire     = s2_valid_reg && out_free;
    assign item_stall = s1_valid_reg || (s2_valid_reg && !out_free);
    assign accept     = item_valid && !item_stall;
    assign s1_adv     = s1_valid_reg && (!(ex_load || ex_store) || addr_done)
                        && (!s2_valid_reg || retire);
    assign addr_start = s1_valid_reg && (ex_load || ex_store) && !busy_reg;

    // Execute stage: operand selection, adder and per-opcode decode.
    always_comb
    begin
        a_val   = rf_d_value;
        b_val   = rf_s_value;
        imm32   = {16'd0, s1_imm_reg};
        is_sub  = (s1_op_reg == OP_SUB_RR) || (s1_op_reg == OP_SUB_RC);
        opnd    = ((s1_op_reg == OP_ADD_RR) || (s1_op_reg == OP_SUB_RR)) ? b_val : imm32;
        sum     = is_sub ? (a_val - opnd) : (a_val + opnd);
        ovf_vec = is_sub ? ((a_val ^ opnd) & (a_val ^ sum))
                         : ((a_val ^ sum) & (opnd ^ sum));
        mem_x   = ((s1_op_reg == OP_LOAD_RC) || (s1_op_reg == OP_STORE_RC)) ? imm32 : b_val;

        take        = 1'b0;
        ex_wr_en    = 1'b0;
        ex_flag_set = 1'b0;
        ex_is_load  = 1'b0;
        ex_wr_idx   = s1_d_reg;
        ex_wr_data  = sum;
        ex_cv       = 1'b0;
        ex_cout     = 8'd0;
        ex_status   = STATUS_OK;
        ex_load     = 1'b0;
        ex_store    = 1'b0;

        case (s1_op_reg)
            OP_ADD_RR, OP_ADD_RC:
            begin
                ex_wr_en = 1'b1;
                if (s1_rst_reg)
                begin
                    ex_wr_data = opnd;
                end
                else
                begin
                    ex_flag_set = s1_flag_reg && ovf_vec[DATA_W-1];
                end
            end
            OP_SUB_RR, OP_SUB_RC:
            begin
                ex_wr_en    = 1'b1;
                ex_flag_set = s1_flag_reg && ovf_vec[DATA_W-1];
            end
            OP_PUSH_POP:
            begin
                ex_status = STATUS_UNSUPPORTED;
            end
            OP_LOAD_RR, OP_LOAD_RC:
            begin
                ex_wr_en   = 1'b1;
                ex_is_load = 1'b1;
                ex_load    = 1'b1;
            end
            OP_STORE_RR, OP_STORE_RC:
            begin
                ex_store = 1'b1;
            end
            OP_BRANCH:
            begin
                if (!s1_offs_reg)
                begin
                    take = s1_flag_reg ? (rf_cmp_value != CMP_EQ) : (rf_cmp_value == CMP_EQ);
                end
                else
                begin
                    take = s1_flag_reg ? (rf_cmp_value == CMP_LT) : (rf_cmp_value != CMP_GT);
                end
                ex_wr_en   = take;
                ex_wr_idx  = PC_IDX;
                ex_wr_data = a_val - 32'd1;
            end
            OP_CMP:
            begin
                ex_wr_en   = 1'b1;
                ex_wr_idx  = CMP_IDX;
                ex_wr_data = compare(a_val, s1_offs_reg ? imm32 : b_val);
            end
            OP_IO:
            begin
                if (s1_flag_reg)
                begin
                    ex_cv   = 1'b1;
                    ex_cout = a_val[7:0];
                end
                else
                begin
                    ex_wr_en   = 1'b1;
                    ex_wr_data = {{(DATA_W-9){s1_ch_reg[8]}}, s1_ch_reg};
                end
            end
            default:
            begin
                ex_status = STATUS_UNKNOWN;
            end
        endcase
    end

    // Execute stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= opcode_t'(operation);
            s1_rst_reg  <= mode_reset;
            s1_flag_reg <= mode_flag;
            s1_offs_reg <= mode_offset;
            s1_d_reg    <= reg_mod(dest_reg);
            s1_imm_reg  <= immediate;
            s1_ch_reg   <= char_in;
        end
    end

    // Write-back stage and output register payload.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_wr_idx_reg  <= ex_wr_idx;
            s2_wr_data_reg <= ex_wr_data;
            s2_cv_reg      <= ex_cv;
            s2_cout_reg    <= ex_cout;
            s2_status_reg  <= ex_status;
        end
        if (retire)
        begin
            cv_out_reg     <= s2_cv_reg;
            cout_out_reg   <= s2_cout_reg;
            pc_out_reg     <= rf_pc_next;
            status_out_reg <= s2_status_reg;
        end
    end

    // Stage occupancy and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            busy_reg         <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s2_wr_en_reg     <= 1'b0;
            s2_flag_set_reg  <= 1'b0;
            s2_is_load_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                busy_reg <= 1'b0;
            end
            else if (addr_start)
            begin
                busy_reg <= 1'b1;
            end

            if (s1_adv)
            begin
                s2_valid_reg    <= 1'b1;
                s2_wr_en_reg    <= ex_wr_en;
                s2_flag_set_reg <= ex_flag_set;
                s2_is_load_reg  <= ex_is_load;
            end
            else if (retire)
            begin
                s2_valid_reg    <= 1'b0;
                s2_wr_en_reg    <= 1'b0;
                s2_flag_set_reg <= 1'b0;
                s2_is_load_reg  <= 1'b0;
            end

            if (retire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Register write-back happens as the transaction leaves for the output.
    assign rf_wctl.en       = retire && s2_wr_en_reg;
    assign rf_wctl.flag_set = retire && s2_flag_set_reg;
    assign rf_wdata         = s2_is_load_reg ? dm_rdata : s2_wr_data_reg;

    assign dm_rd_en = s1_adv && ex_load;
    assign dm_wr_en = s1_adv && ex_store;

    vmx_regfile #(
        .NUM_REGS (NUM_REGS),
        .FLAG_REG (FLAG_REG),
        .CMP_REG  (CMP_REG),
        .PC_REG   (PC_REG)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_d_idx  (reg_mod(dest_reg)),
        .rd_s_idx  (reg_mod(source_reg)),
        .wr_ctl    (rf_wctl),
        .wr_idx    (s2_wr_idx_reg),
        .wr_data   (rf_wdata),
        .d_value   (rf_d_value),
        .s_value   (rf_s_value),
        .cmp_value (rf_cmp_value),
        .pc_next   (rf_pc_next)
    );

    vmx_addr_mod #(
        .MEM_WORDS (MEM_WORDS)
    ) u_addr_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (addr_start),
        .clear (s1_adv),
        .value (mem_x),
        .done  (addr_done),
        .addr  (dm_addr)
    );

    vmx_data_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_data_mem (
        .clk     (clk),
        .rd_en   (dm_rd_en),
        .rd_addr (dm_addr),
        .rd_data (dm_rdata),
        .wr_en   (dm_wr_en),
        .wr_addr (dm_addr),
        .wr_data (a_val)
    );

    assign result_valid   = result_valid_reg;
    assign char_out_valid = cv_out_reg;
    assign char_out       = cout_out_reg;
    assign pc_value       = pc_out_reg;
    assign status         = status_out_reg;

    // The execute stage only holds a transaction while write-back is empty.
    a_stage_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !s2_valid_reg)
        else $error("execute and write-back stages occupied together");

    // An accepted transaction is in the execute stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted transaction did not enter the execute stage");

    // A new result only appears after a transaction left write-back.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s2_valid_reg))
        else $error("result appeared without a retiring transaction");

    // The data memory is never read and written in the same cycle.
    a_mem_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(dm_rd_en && dm_wr_en))
        else $error("data memory read and write in the same cycle");

endmodule

`default_nettype wire
